### sv/rmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwc_pkg
// Shared types and constants of the ray march wall column engine.
// ----------------------------------------------------------------------------
package rmwc_pkg;

  localparam int POS_W = 25;

  localparam logic [16:0] ONE_CELL   = 17'd65536;
  localparam logic [16:0] STEP_LIMIT = 17'd65536;
  localparam logic [16:0] POLY_A     = 17'd102944;
  localparam logic [15:0] POLY_B     = 16'd42048;
  localparam logic [15:0] POLY_C     = 16'd4640;

  localparam logic [2:0] CFG_PLAYER_X   = 3'd0;
  localparam logic [2:0] CFG_PLAYER_Y   = 3'd1;
  localparam logic [2:0] CFG_MAP_COLS   = 3'd2;
  localparam logic [2:0] CFG_MAP_ROWS   = 3'd3;
  localparam logic [2:0] CFG_MARCH_STEP = 3'd4;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  localparam logic COMP_X = 1'b0;
  localparam logic COMP_Y = 1'b1;

  typedef struct packed {
    logic       action;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       cell_is_wall;
    logic [11:0] heading;
    logic [9:0] screen_col;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [1:0]  wall_face;
    logic [15:0] wall_dist;
    logic [5:0]  tex_col;
    logic [7:0]  wall_top;
    logic [8:0]  wall_len;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [21:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [21:0] player_pos_x;
    logic [21:0] player_pos_y;
    logic [6:0]  map_cols;
    logic [6:0]  map_rows;
    logic [15:0] march_step;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_WR, OP_SQ, OP_X2C, OP_X2T, OP_XT, OP_SIN,
    OP_INC, OP_INCW, OP_START, OP_PROBE, OP_ADV, OP_DDX, OP_DDY, OP_SUM,
    OP_SQRT, OP_TEXM, OP_DIV, OP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   comp;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cast;
    logic clr_last;
    logic blocked;
    logic at_limit;
    logic cnt_zero;
  } dp_stat_t;

endpackage

### sv/rmwc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwc_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface rmwc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rmwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwc_ctrl
// Sequencer: map clearing, cell writes and the cast sequence of the datapath.
// ----------------------------------------------------------------------------
module rmwc_ctrl import rmwc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_SQ, S_X2C, S_X2T, S_XT, S_SIN, S_INC, S_INCW,
    S_START, S_PROBE, S_CHECK, S_DDX, S_DDY, S_SUM, S_SQRT, S_TEXM, S_DIV, S_RES
  } state_t;

  state_t state_r;
  logic   comp_r;
  logic   out_valid_r;
  logic   out_free;
  logic   hit;

  assign out_free  = !out_valid_r || out_ready;
  assign hit       = stat.blocked || stat.at_limit;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.comp = comp_r;
    cmd.op   = OP_NONE;
    unique case (state_r)
      S_CLEAR: cmd.op = OP_CLR;
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_DISP:  if (!stat.is_cast) cmd.op = OP_WR;
      S_SQ:    cmd.op = OP_SQ;
      S_X2C:   cmd.op = OP_X2C;
      S_X2T:   cmd.op = OP_X2T;
      S_XT:    cmd.op = OP_XT;
      S_SIN:   cmd.op = OP_SIN;
      S_INC:   cmd.op = OP_INC;
      S_INCW:  cmd.op = OP_INCW;
      S_START: cmd.op = OP_START;
      S_PROBE: cmd.op = OP_PROBE;
      S_CHECK: if (!hit) cmd.op = OP_ADV;
      S_DDX:   cmd.op = OP_DDX;
      S_DDY:   cmd.op = OP_DDY;
      S_SUM:   cmd.op = OP_SUM;
      S_SQRT:  cmd.op = OP_SQRT;
      S_TEXM:  cmd.op = OP_TEXM;
      S_DIV:   cmd.op = OP_DIV;
      S_RES:   if (out_free) cmd.op = OP_RES;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      comp_r      <= COMP_X;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RES && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: if (stat.clr_last) state_r <= S_IDLE;
        S_IDLE:  if (in_valid) state_r <= S_DISP;
        S_DISP: begin
          comp_r  <= COMP_X;
          state_r <= stat.is_cast ? S_SQ : S_IDLE;
        end
        S_SQ:  state_r <= S_X2C;
        S_X2C: state_r <= S_X2T;
        S_X2T: state_r <= S_XT;
        S_XT:  state_r <= S_SIN;
        S_SIN: begin
          if (comp_r == COMP_X) begin
            comp_r  <= COMP_Y;
            state_r <= S_SQ;
          end else begin
            comp_r  <= COMP_X;
            state_r <= S_INC;
          end
        end
        S_INC: state_r <= S_INCW;
        S_INCW: begin
          if (comp_r == COMP_X) begin
            comp_r  <= COMP_Y;
            state_r <= S_INC;
          end else begin
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_PROBE;
        S_PROBE: state_r <= S_CHECK;
        S_CHECK: state_r <= hit ? S_DDX : S_PROBE;
        S_DDX:   state_r <= S_DDY;
        S_DDY:   state_r <= S_SUM;
        S_SUM:   state_r <= S_SQRT;
        S_SQRT:  if (stat.cnt_zero) state_r <= S_TEXM;
        S_TEXM:  state_r <= S_DIV;
        S_DIV:   if (stat.cnt_zero) state_r <= S_RES;
        S_RES:   if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/rmwc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwc_datapath
// Wall map memory, shared multiplier, march registers, root and divide units.
// ----------------------------------------------------------------------------
module rmwc_datapath import rmwc_pkg::*; #(
  parameter int MAP_SIDE      = 64,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_SIZE      = 64,
  parameter int ANGLE_BITS    = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  output out_item_t res
);

  localparam int CW    = $clog2(MAP_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int QW    = $clog2(SCREEN_HEIGHT + 1);
  localparam int NW    = QW + 16;
  localparam logic [NW-1:0] DIV_NUM = NW'(64'(SCREEN_HEIGHT) << 16);
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(24);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);

  logic mem [DEPTH];
  logic mem_q_r;
  logic oob_r;
  logic [AW-1:0] clr_addr_r;

  in_item_t item_r;
  out_item_t res_r;
  logic [16:0] x_r;
  logic [16:0] x2_r;
  logic [47:0] prod_r;
  logic [47:0] acc_r;
  logic signed [17:0] dx_r, dy_r, ix_r, iy_r;
  logic signed [POS_W-1:0] rx_r, ry_r, prx_r, pry_r;
  logic [16:0] n_r;
  logic [49:0] rad_r;
  logic [24:0] root_r;
  logic [27:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [24:0] d16_r;
  logic [25:0] drem_r;
  logic [QW-1:0] nsh_r;
  logic [QW-1:0] quot_r;
  logic [1:0] face_r;

  // angle and quarter wave
  logic [15:0] a16, ang;
  logic [14:0] pofs, pq;
  logic [16:0] xv;
  logic [15:0] t1;
  logic [16:0] t2;
  logic [16:0] s_val;
  logic signed [17:0] s_signed;
  logic signed [17:0] d_sel;
  logic [16:0] d_mag;
  logic [16:0] inc_mag;
  logic signed [17:0] inc_signed;

  always_comb begin
    a16  = 16'((32'(item_r.heading) & ((32'd1 << ANGLE_BITS) - 32'd1))
               << (16 - ANGLE_BITS));
    ang  = (cmd.comp == COMP_X) ? a16 + 16'd16384 : a16;
    pofs = {1'b0, ang[13:0]};
    pq   = ang[14] ? 15'd16384 - pofs : pofs;
    xv   = {pq, 2'b00};
    t1   = POLY_B - prod_r[31:16];
    t2   = POLY_A - prod_r[32:16];
    s_val = (prod_r[47:16] > 32'(ONE_CELL)) ? ONE_CELL : prod_r[32:16];
    s_signed = ang[15] ? -$signed({1'b0, s_val}) : $signed({1'b0, s_val});
    d_sel = (cmd.comp == COMP_X) ? dx_r : dy_r;
    d_mag = d_sel[17] ? 17'(-d_sel) : 17'(d_sel);
    inc_mag = {1'b0, prod_r[31:16]};
    inc_signed = d_sel[17] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  end

  // map bounds and memory addressing
  logic [8:0] eff_cols, eff_rows;
  logic oob_nxt;
  logic [AW-1:0] rd_addr, wr_addr, mem_wa;
  logic [CW+5:0] wc_ext, wr_ext;
  logic wr_in_map;
  logic mem_we, mem_wd;

  always_comb begin
    eff_cols = (9'(cfg.map_cols) > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : 9'(cfg.map_cols);
    eff_rows = (9'(cfg.map_rows) > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : 9'(cfg.map_rows);
    oob_nxt  = rx_r[POS_W-1] || ry_r[POS_W-1] ||
               ({1'b0, rx_r[23:16]} >= eff_cols) || ({1'b0, ry_r[23:16]} >= eff_rows);
    rd_addr  = {ry_r[16 +: CW], rx_r[16 +: CW]};
    wc_ext   = (CW + 6)'(item_r.cell_col);
    wr_ext   = (CW + 6)'(item_r.cell_row);
    wr_addr  = {wr_ext[CW-1:0], wc_ext[CW-1:0]};
    wr_in_map = (32'(item_r.cell_col) < MAP_SIDE) && (32'(item_r.cell_row) < MAP_SIDE);
    mem_we = (cmd.op == OP_CLR) || ((cmd.op == OP_WR) && wr_in_map);
    mem_wa = (cmd.op == OP_CLR) ? clr_addr_r : wr_addr;
    mem_wd = (cmd.op == OP_CLR) ? 1'b0 : item_r.cell_is_wall;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.op == OP_PROBE) mem_q_r <= mem[rd_addr];
  end

  // hit geometry
  logic signed [POS_W-1:0] px_s, py_s, ddx, ddy;
  logic [23:0] ddx_mag, ddy_mag;
  logic signed [8:0] cpx, cpy, crx, cry;
  logic [16:0] fx, fy, tex_f;
  logic [1:0] face_nxt;

  always_comb begin
    px_s = $signed(POS_W'(cfg.player_pos_x));
    py_s = $signed(POS_W'(cfg.player_pos_y));
    ddx  = rx_r - px_s;
    ddy  = ry_r - py_s;
    ddx_mag = ddx[POS_W-1] ? 24'(-ddx) : 24'(ddx);
    ddy_mag = ddy[POS_W-1] ? 24'(-ddy) : 24'(ddy);
    cpx = $signed(prx_r[24:16]);
    cpy = $signed(pry_r[24:16]);
    crx = $signed(rx_r[24:16]);
    cry = $signed(ry_r[24:16]);
    fx  = {1'b0, rx_r[15:0]};
    fy  = {1'b0, ry_r[15:0]};
    priority if (cpx > crx) begin
      face_nxt = FACE_EAST;
      tex_f    = ONE_CELL - fy;
    end else if (cpy > cry) begin
      face_nxt = FACE_SOUTH;
      tex_f    = fx;
    end else if (cpx < crx) begin
      face_nxt = FACE_WEST;
      tex_f    = fy;
    end else begin
      face_nxt = FACE_NORTH;
      tex_f    = ONE_CELL - fx;
    end
  end

  // shared multiplier operands
  logic [23:0] ma, mb;
  logic mul_en;

  always_comb begin
    ma = '0;
    mb = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_SQ:   begin ma = 24'(xv);           mb = 24'(xv);             end
      OP_X2C:  begin ma = 24'(prod_r[32:16]); mb = 24'(POLY_C);         end
      OP_X2T:  begin ma = 24'(x2_r);         mb = 24'(t1);             end
      OP_XT:   begin ma = 24'(x_r);          mb = 24'(t2);             end
      OP_INC:  begin ma = 24'(d_mag);        mb = 24'(cfg.march_step); end
      OP_DDX:  begin ma = ddx_mag;           mb = ddx_mag;             end
      OP_DDY:  begin ma = ddy_mag;           mb = ddy_mag;             end
      OP_TEXM: begin ma = 24'(tex_f);        mb = 24'(TEX_SIZE);       end
      default: mul_en = 1'b0;
    endcase
  end

  // one root bit and one quotient bit per step
  logic [27:0] sq_rem2, sq_trial;
  logic sq_ge;
  logic [25:0] dv_rem2;
  logic dv_ge;
  logic [24:0] d16_nxt;

  always_comb begin
    sq_rem2  = {rem_r[25:0], rad_r[49:48]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = (sq_rem2 >= sq_trial);
    dv_rem2  = {drem_r[24:0], nsh_r[QW-1]};
    dv_ge    = (dv_rem2 >= {1'b0, d16_r});
    d16_nxt  = (root_r < 25'(ONE_CELL)) ? 25'(ONE_CELL) : root_r;
  end

  // result formatting
  logic [QW-1:0] top_w;
  logic [31:0] tex_t;
  out_item_t res_nxt;

  always_comb begin
    top_w = (QW'(SCREEN_HEIGHT) - quot_r) >> 1;
    tex_t = prod_r[47:16];
    if (tex_t > 32'(TEX_SIZE - 1)) tex_t = 32'(TEX_SIZE - 1);
    if (tex_t > 32'd63) tex_t = 32'd63;
    res_nxt.out_col   = item_r.screen_col;
    res_nxt.wall_face = face_r;
    res_nxt.wall_dist = (d16_r[24:8] > 17'd65535) ? 16'hFFFF : d16_r[23:8];
    res_nxt.tex_col   = 6'(tex_t);
    res_nxt.wall_top  = (32'(top_w) > 32'd255) ? 8'd255 : 8'(top_w);
    res_nxt.wall_len  = (32'(quot_r) > 32'd511) ? 9'd511 : 9'(quot_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      cnt_r      <= '0;
      n_r        <= '0;
      oob_r      <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.op == OP_PROBE) oob_r <= oob_nxt;
      if (cmd.op == OP_START) n_r <= 17'd1;
      if (cmd.op == OP_ADV) n_r <= n_r + 17'd1;
      unique case (cmd.op)
        OP_SUM:  cnt_r <= SQ_LAST;
        OP_TEXM: cnt_r <= DIV_LAST;
        OP_SQRT, OP_DIV: cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= 48'(ma) * 48'(mb);
    unique case (cmd.op)
      OP_LOAD: item_r <= in_item;
      OP_SQ:   x_r <= xv;
      OP_X2C:  x2_r <= prod_r[32:16];
      OP_SIN: begin
        if (cmd.comp == COMP_X) dx_r <= s_signed;
        else dy_r <= s_signed;
      end
      OP_INCW: begin
        if (cmd.comp == COMP_X) ix_r <= inc_signed;
        else iy_r <= inc_signed;
      end
      OP_START: begin
        prx_r <= px_s;
        pry_r <= py_s;
        rx_r  <= px_s + POS_W'(ix_r);
        ry_r  <= py_s + POS_W'(iy_r);
      end
      OP_ADV: begin
        prx_r <= rx_r;
        pry_r <= ry_r;
        rx_r  <= rx_r + POS_W'(ix_r);
        ry_r  <= ry_r + POS_W'(iy_r);
      end
      OP_DDY: acc_r <= prod_r;
      OP_SUM: begin
        rad_r  <= 50'(acc_r) + 50'(prod_r);
        root_r <= '0;
        rem_r  <= '0;
      end
      OP_SQRT: begin
        rad_r  <= {rad_r[47:0], 2'b00};
        rem_r  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
        root_r <= {root_r[23:0], sq_ge};
      end
      OP_TEXM: begin
        face_r <= face_nxt;
        d16_r  <= d16_nxt;
        drem_r <= 26'(DIV_NUM[NW-1:QW]);
        nsh_r  <= DIV_NUM[QW-1:0];
        quot_r <= '0;
      end
      OP_DIV: begin
        drem_r <= dv_ge ? dv_rem2 - {1'b0, d16_r} : dv_rem2;
        nsh_r  <= nsh_r << 1;
        quot_r <= {quot_r[QW-2:0], dv_ge};
      end
      OP_RES: res_r <= res_nxt;
      default: ;
    endcase
  end

  assign stat.is_cast  = item_r.action;
  assign stat.clr_last = &clr_addr_r;
  assign stat.blocked  = oob_r || mem_q_r;
  assign stat.at_limit = (n_r == STEP_LIMIT);
  assign stat.cnt_zero = (cnt_r == '0);
  assign res = res_r;

endmodule

### sv/ray_march_wall_column_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_march_wall_column_top
// Fixed-step ray march over a one-bit wall map, returns one wall slice per cast.
// ----------------------------------------------------------------------------
// in_chan takes requests: action 0 writes one map cell, action 1 casts a ray.
// out_chan returns one result per cast (face, distance, texture column, slice
// top and height); writes give no result. cfg_chan writes the player position,
// map size and step length; it is always ready, and the user must write it only
// while idle, which the block itself does not enforce. A cast marches sample by
// sample, each a map memory read, then a hit test; QW = clog2(SCREEN_HEIGHT+1)
// is the quotient width; the sine and step products share one multiplier.
// One request is worked on at a time; the result sits in an output register,
// so the next request is accepted while it waits. If the receiver stalls and
// a second result is ready, the block holds in its last step until the slot
// frees. After reset the map memory is cleared one cell per cycle, all
// MAP_SIDE*MAP_SIDE cells (rounded up to a power of two per side), before
// in_chan becomes ready; configuration returns to its reset values at once.
// ----------------------------------------------------------------------------
module ray_march_wall_column_top import rmwc_pkg::*; #(
  parameter int MAP_SIDE      = 64,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_SIZE      = 64,
  parameter int ANGLE_BITS    = 12
) (
  input logic         clk,
  input logic         rst_n,
  rmwc_chan_if.sink   in_chan,
  rmwc_chan_if.source out_chan,
  rmwc_chan_if.sink   cfg_chan
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  cfg_wr_t  cfg_req;

  assign cfg_chan.ready = 1'b1;
  assign cfg_req = cfg_chan.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player_pos_x <= '0;
      cfg_r.player_pos_y <= '0;
      cfg_r.map_cols     <= 7'd64;
      cfg_r.map_rows     <= 7'd64;
      cfg_r.march_step   <= 16'd4096;
    end else if (cfg_chan.valid) begin
      unique case (cfg_req.index)
        CFG_PLAYER_X:   cfg_r.player_pos_x <= cfg_req.value;
        CFG_PLAYER_Y:   cfg_r.player_pos_y <= cfg_req.value;
        CFG_MAP_COLS:   cfg_r.map_cols     <= cfg_req.value[6:0];
        CFG_MAP_ROWS:   cfg_r.map_rows     <= cfg_req.value[6:0];
        CFG_MARCH_STEP: cfg_r.march_step   <= cfg_req.value[15:0];
        default: ;
      endcase
    end
  end

  rmwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rmwc_datapath #(
    .MAP_SIDE      (MAP_SIDE),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEX_SIZE      (TEX_SIZE),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .cfg     (cfg_r),
    .in_item (in_chan.data),
    .res     (out_chan.data)
  );

endmodule

### sv/rmwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwc_checker
// Port-level checks of the ray march wall column engine.
// ----------------------------------------------------------------------------
module rmwc_checker import rmwc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // distance is floored at one cell
  a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.wall_dist >= 16'h0100)
    else $error("distance below one cell");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels active after reset");

endmodule

bind ray_march_wall_column_top rmwc_checker u_rmwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

### verif/tb_ray_march_wall_column_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_march_wall_column_top
// Self-checking bench for the fixed-step ray march wall column engine.
// ----------------------------------------------------------------------------
// Requests (map cell writes and ray casts) are queued by the stimulus block and
// fed by a clocked driver with random gaps. Each accepted cast is predicted
// against a local copy of the wall map and registers, and the result channel,
// stalled at random, is compared field by field in order. Registers change only
// while the engine is idle, across directed corner phases and random phases.
// ----------------------------------------------------------------------------
module tb_ray_march_wall_column_top;
  import rmwc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   errs = 0;

  rmwc_chan_if #(.payload_t(in_item_t))  in_if ();
  rmwc_chan_if #(.payload_t(out_item_t)) out_if ();
  rmwc_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();

  ray_march_wall_column_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t  req_q[$];
  out_item_t slice_q[$];
  bit        wall_m[0:4095];
  cfg_t      cfg_m;

  // ---------------------------------------------------------------- predictor
  function automatic longint quarter_wave(longint p);
    longint x, x2, t, s;
    x  = p << 2;
    x2 = (x * x) >> 16;
    t  = longint'(POLY_B) - ((x2 * longint'(POLY_C)) >> 16);
    t  = longint'(POLY_A) - ((x2 * t) >> 16);
    s  = (x * t) >> 16;
    if (s > 65536) s = 65536;
    return s;
  endfunction

  function automatic longint sine_q16(longint a);
    longint q, p, s;
    a = a & 65535;
    q = a >> 14;
    p = a & 16383;
    if (q[0]) p = 16384 - p;
    s = quarter_wave(p);
    return q[1] ? -s : s;
  endfunction

  function automatic longint step_of(longint d, longint stp);
    longint v;
    v = ((d < 0 ? -d : d) * stp) >> 16;
    return d < 0 ? -v : v;
  endfunction

  function automatic bit is_blocked(longint x, longint y);
    longint cols, rows;
    cols = cfg_m.map_cols > 64 ? 64 : cfg_m.map_cols;
    rows = cfg_m.map_rows > 64 ? 64 : cfg_m.map_rows;
    if (x < 0 || y < 0 || x >= cols * 65536 || y >= rows * 65536) return 1'b1;
    return wall_m[(y >>> 16) * 64 + (x >>> 16)];
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tex_of(longint f);
    longint t;
    t = (f * 64) >> 16;
    if (t > 63) t = 63;
    return t;
  endfunction

  function automatic out_item_t wall_slice_of(in_item_t it);
    out_item_t res;
    longint a16, ix, iy, px, py, rx, ry, prx, pry, cpx, cpy, crx, cry, fx, fy;
    longint ddx, ddy, tex, len, top;
    longint unsigned d16, dist_q;
    int n;
    a16 = longint'(it.heading) << 4;
    ix  = step_of(sine_q16(a16 + 16384), cfg_m.march_step);
    iy  = step_of(sine_q16(a16), cfg_m.march_step);
    px  = cfg_m.player_pos_x;
    py  = cfg_m.player_pos_y;
    prx = px;
    pry = py;
    rx  = px + ix;
    ry  = py + iy;
    n   = 1;
    while (!is_blocked(rx, ry) && n < 65536) begin
      prx = rx;
      pry = ry;
      rx += ix;
      ry += iy;
      n++;
    end
    cpx = prx >>> 16;
    cpy = pry >>> 16;
    crx = rx >>> 16;
    cry = ry >>> 16;
    fx  = rx - crx * 65536;
    fy  = ry - cry * 65536;
    if (cpx > crx) begin
      res.wall_face = FACE_EAST;
      tex = tex_of(65536 - fy);
    end else if (cpy > cry) begin
      res.wall_face = FACE_SOUTH;
      tex = tex_of(fx);
    end else if (cpx < crx) begin
      res.wall_face = FACE_WEST;
      tex = tex_of(fy);
    end else begin
      res.wall_face = FACE_NORTH;
      tex = tex_of(65536 - fx);
    end
    ddx = rx - px;
    ddy = ry - py;
    d16 = int_root(longint'(ddx * ddx) + longint'(ddy * ddy));
    if (d16 < 65536) d16 = 65536;
    dist_q = d16 >> 8;
    if (dist_q > 65535) dist_q = 65535;
    len = (480 * 65536) / d16;
    top = (480 - len) / 2;
    if (len > 511) len = 511;
    if (top > 255) top = 255;
    res.out_col  = it.screen_col;
    res.wall_dist = dist_q[15:0];
    res.tex_col  = tex[5:0];
    res.wall_top = top[7:0];
    res.wall_len = len[8:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (!in_if.data.action)
          wall_m[in_if.data.cell_row * 64 + in_if.data.cell_col] = in_if.data.cell_is_wall;
        else
          slice_q.push_back(wall_slice_of(in_if.data));
      end
      if (!in_if.valid || in_if.ready) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= req_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errs++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (slice_q.size() == 0) begin
          report_mismatch("unrequested result, out_col", out_if.data.out_col, -1);
        end else begin
          want = slice_q.pop_front();
          if (out_if.data.out_col != want.out_col)
            report_mismatch("out_col", out_if.data.out_col, want.out_col);
          if (out_if.data.wall_face != want.wall_face)
            report_mismatch("wall_face", out_if.data.wall_face, want.wall_face);
          if (out_if.data.wall_dist != want.wall_dist)
            report_mismatch("wall_dist", out_if.data.wall_dist, want.wall_dist);
          if (out_if.data.tex_col != want.tex_col)
            report_mismatch("tex_col", out_if.data.tex_col, want.tex_col);
          if (out_if.data.wall_top != want.wall_top)
            report_mismatch("wall_top", out_if.data.wall_top, want.wall_top);
          if (out_if.data.wall_len != want.wall_len)
            report_mismatch("wall_len", out_if.data.wall_len, want.wall_len);
        end
      end
      out_if.ready <= calm || $urandom_range(99) >= 17;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_cell(int c, int r, bit w);
    in_item_t it;
    it = '0;
    it.cell_col = 6'(c);
    it.cell_row = 6'(r);
    it.cell_is_wall = w;
    it.heading = 12'($urandom);
    it.screen_col = 10'($urandom);
    req_q.push_back(it);
  endtask

  task automatic push_cast(int ang, int col);
    in_item_t it;
    it = '0;
    it.action = 1'b1;
    it.cell_col = 6'($urandom);
    it.cell_row = 6'($urandom);
    it.cell_is_wall = 1'($urandom);
    it.heading = 12'(ang);
    it.screen_col = 10'(col);
    req_q.push_back(it);
  endtask

  // engine is idle once every request is taken and every slice returned;
  // a trailing map write may still be in progress
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || slice_q.size() != 0 || in_if.valid);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, int unsigned val);
    bit ok;
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val[21:0]};
    do begin
      @(negedge clk);
      ok = cfg_if.ready;
      @(posedge clk);
    end while (!ok);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_PLAYER_X:   cfg_m.player_pos_x = val[21:0];
      CFG_PLAYER_Y:   cfg_m.player_pos_y = val[21:0];
      CFG_MAP_COLS:   cfg_m.map_cols     = val[6:0];
      CFG_MAP_ROWS:   cfg_m.map_rows     = val[6:0];
      CFG_MARCH_STEP: cfg_m.march_step   = val[15:0];
      default: ;
    endcase
  endtask

  initial begin
    int cols, rows, span;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    cfg_m = '{player_pos_x: 0, player_pos_y: 0, map_cols: 64, map_rows: 64,
              march_step: 4096};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small room, walls on all four sides of the player
    set_reg(CFG_MAP_COLS, 8);
    set_reg(CFG_MAP_ROWS, 8);
    set_reg(CFG_PLAYER_X, 32'h38000);
    set_reg(CFG_PLAYER_Y, 32'h38000);
    set_reg(CFG_MARCH_STEP, 16384);
    push_cell(0, 0, 1);
    push_cell(63, 63, 1);
    push_cell(63, 63, 0);
    push_cell(5, 3, 1);
    push_cell(1, 3, 1);
    push_cell(3, 5, 1);
    push_cell(3, 1, 1);
    push_cast(0, 0);
    push_cast(1024, 1023);
    push_cast(2048, 5);
    push_cast(3072, 512);
    push_cast(4095, 341);
    push_cast(512, 682);
    push_cast(1536, 7);
    wait_idle();

    // empty map: first sample hits
    set_reg(CFG_MAP_COLS, 0);
    push_cast(300, 1);
    wait_idle();
    // oversize map, longest step
    set_reg(CFG_MAP_COLS, 127);
    set_reg(CFG_MAP_ROWS, 127);
    set_reg(CFG_MARCH_STEP, 65535);
    push_cast(700, 2);
    push_cast(2500, 3);
    wait_idle();
    // player far outside the map in use
    set_reg(CFG_MAP_COLS, 8);
    set_reg(CFG_MAP_ROWS, 0);
    set_reg(CFG_PLAYER_X, 32'h3FFFFF);
    set_reg(CFG_PLAYER_Y, 32'h3FFFFF);
    push_cast(2048, 4);
    wait_idle();
    set_reg(CFG_MAP_ROWS, 64);
    set_reg(CFG_MAP_COLS, 64);
    set_reg(CFG_PLAYER_X, 0);
    set_reg(CFG_PLAYER_Y, 0);
    push_cast(3000, 6);
    wait_idle();
    // endless march: zero and minimum step both run out the sample limit
    set_reg(CFG_PLAYER_X, 32'h20000);
    set_reg(CFG_PLAYER_Y, 32'h20000);
    set_reg(CFG_MARCH_STEP, 0);
    push_cast(100, 8);
    wait_idle();
    set_reg(CFG_MARCH_STEP, 1);
    push_cast(0, 9);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      if ($urandom_range(9) < 7) begin
        cols = $urandom_range(3, 16);
        rows = $urandom_range(3, 16);
      end else begin
        cols = $urandom_range(9) < 5 ? 64 : $urandom_range(65, 127);
        rows = $urandom_range(9) < 2 ? 0 : $urandom_range(1, 127);
      end
      set_reg(CFG_MAP_COLS, cols);
      set_reg(CFG_MAP_ROWS, rows);
      span = (cols > 16 || rows > 16) ? 16384 : ($urandom_range(9) < 8 ? 8192 : 2048);
      set_reg(CFG_MARCH_STEP, $urandom_range(span, 65535));
      if ($urandom_range(9) < 8) begin
        set_reg(CFG_PLAYER_X, $urandom_range((cols > 64 ? 64 : (cols == 0 ? 1 : cols)) * 65536 - 1));
        set_reg(CFG_PLAYER_Y, $urandom_range((rows > 64 ? 64 : (rows == 0 ? 1 : rows)) * 65536 - 1));
      end else begin
        set_reg(CFG_PLAYER_X, $urandom_range(32'h3FFFFF));
        set_reg(CFG_PLAYER_Y, $urandom_range(32'h3FFFFF));
      end
      for (int k = 0; k < 215; k++) begin
        if ($urandom_range(99) < 35) begin
          if ($urandom_range(9) < 8)
            push_cell($urandom_range(cols > 64 ? 63 : (cols == 0 ? 0 : cols - 1)),
                      $urandom_range(rows > 64 ? 63 : (rows == 0 ? 0 : rows - 1)),
                      $urandom_range(99) < 30);
          else
            push_cell($urandom_range(63), $urandom_range(63), $urandom_range(1) == 1);
        end else begin
          push_cast($urandom_range(4095), $urandom_range(1023));
        end
      end
      wait_idle();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk);
    if (errs == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

endmodule
